FILE: hdl/ltkm_pkg.sv
// ----------------------------------------------------------------------------
// ltkm_pkg
// shared types, codes and helpers of the loser tree k-way merge block
// ----------------------------------------------------------------------------
package ltkm_pkg;

    localparam int KEY_W  = 32;
    localparam int CFG_W  = 4;
    localparam int SID_W  = 3;
    localparam int ACT_W  = 2;

    // streams merged after reset
    localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

    // input transaction codes
    typedef enum logic [ACT_W-1:0] {
        ACT_LOAD    = 2'd0,
        ACT_BUILD   = 2'd1,
        ACT_ADVANCE = 2'd2
    } t_action;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_B_ADDR,
        ST_B_KEY,
        ST_B_CMP,
        ST_A_NODE,
        ST_A_KEY,
        ST_A_CMP,
        ST_E_READ,
        ST_E_OUT
    } t_state;

    // signed strictly-less compare of two keys
    function automatic logic key_less(input logic signed [KEY_W-1:0] a,
                                      input logic signed [KEY_W-1:0] b);
        return a < b;
    endfunction

endpackage

FILE: hdl/ltkm_if.sv
// ----------------------------------------------------------------------------
// ltkm channel interfaces
// valid/ready channels for input items, results and the configuration write
// ----------------------------------------------------------------------------
interface ltkm_in_if;
    logic                                valid;
    logic                                ready;
    logic [ltkm_pkg::ACT_W-1:0]          action;
    logic [ltkm_pkg::SID_W-1:0]          stream;
    logic signed [ltkm_pkg::KEY_W-1:0]   key;
    logic                                key_valid;

    modport source (output valid, action, stream, key, key_valid, input ready);
    modport sink   (input valid, action, stream, key, key_valid, output ready);
endinterface

interface ltkm_out_if;
    logic                                valid;
    logic                                ready;
    logic [ltkm_pkg::SID_W-1:0]          winner_stream;
    logic signed [ltkm_pkg::KEY_W-1:0]   winner_key;
    logic                                winner_valid;

    modport source (output valid, winner_stream, winner_key, winner_valid, input ready);
    modport sink   (input valid, winner_stream, winner_key, winner_valid, output ready);
endinterface

interface ltkm_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [ltkm_pkg::CFG_W-1:0]          streams_in_use;

    modport source (output valid, streams_in_use, input ready);
    modport sink   (input valid, streams_in_use, output ready);
endinterface

FILE: hdl/ltkm_ram.sv
// ----------------------------------------------------------------------------
// ltkm_ram
// one write port, two read ports with registered read data and read enables
// ----------------------------------------------------------------------------
module ltkm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  logic [WIDTH-1:0]           i_wdata,
    input  logic                       i_re_a,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr_a,
    output logic [WIDTH-1:0]           o_rdata_a,
    input  logic                       i_re_b,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr_b,
    output logic [WIDTH-1:0]           o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re_a) begin
            o_rdata_a <= r_mem[i_raddr_a];
        end
        if (i_re_b) begin
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

FILE: hdl/loser_tree_kway_merge_top.sv
// ----------------------------------------------------------------------------
// loser_tree_kway_merge_top
// loser tree merge of up to MAX_STREAMS sorted streams of signed 32-bit keys
// ----------------------------------------------------------------------------
// load: handled in the idle state, no result; the next transaction is taken right after
// build over n streams: B_ADDR, B_KEY, B_CMP per inner node, then E_READ, E_OUT
// advance: A_NODE, A_KEY and A_CMP per level of the leaf-to-root path, 3 levels for eight
//   streams; each level is a loser read, a key read and a compare-and-write-back
// one transaction at a time; a finished result waits in the output register
// reset: sequencer idle, presence and loser valid bits cleared, winner 0,
//   streams_in_use 8; key memory is not cleared, so no clearing pass
module loser_tree_kway_merge_top #(
    parameter int MAX_STREAMS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ltkm_in_if.sink     i_in,
    ltkm_out_if.source  o_out,
    ltkm_cfg_if.sink    i_cfg
);

    // stream index width and a width that also holds the stream count
    localparam int SW = $clog2(MAX_STREAMS);
    localparam int CW = SW + 1;
    localparam int KW = ltkm_pkg::KEY_W;

    // ------------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------------
    ltkm_pkg::t_state              r_state,    n_state;
    logic [ltkm_pkg::CFG_W-1:0]    r_cfg;
    logic [MAX_STREAMS-1:0]        r_present,  n_present;   // head present flags
    logic [SW-1:0]                 r_winner,   n_winner;    // current winner stream
    logic [SW-1:0]                 r_i,        n_i;         // build: inner node
    logic [SW-1:0]                 r_node,     n_node;      // advance: node on the path
    logic signed [KW-1:0]          r_cur_key,  n_cur_key;   // key of climbing stream
    logic                          r_cur_pres, n_cur_pres;
    logic [SW-1:0]                 r_l,        n_l;         // left stream, or challenger
    logic [SW-1:0]                 r_r,        n_r;         // right stream
    logic                          r_l_leaf,   n_l_leaf;
    logic                          r_r_leaf,   n_r_leaf;
    logic                          r_out_valid, n_out_valid;
    logic [ltkm_pkg::SID_W-1:0]    r_o_stream, n_o_stream;
    logic signed [KW-1:0]          r_o_key,    n_o_key;
    logic                          r_o_kv,     n_o_kv;

    // loser memory with a valid bit per entry, invalid entries read as zero
    logic [SW-1:0]                 r_lmem [MAX_STREAMS];
    logic [MAX_STREAMS-1:0]        r_lvalid;
    logic [SW-1:0]                 r_lrd;
    logic                          r_lrd_v;

    // ------------------------------------------------------------------------
    // memory port controls
    // ------------------------------------------------------------------------
    logic                  k_we, k_re_a, k_re_b;
    logic [SW-1:0]         k_waddr, k_raddr_a, k_raddr_b;
    logic signed [KW-1:0]  k_wdata, k_rdata_a, k_rdata_b;

    logic                  w_we, w_re_a, w_re_b;
    logic [SW-1:0]         w_waddr, w_raddr_a, w_raddr_b, w_wdata, w_rdata_a, w_rdata_b;

    logic                  lw_en, lr_en;
    logic [SW-1:0]         lw_addr, lw_data, l_rd;

    // ------------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------------
    logic [CW-1:0] n_live;      // streams in use, clamped to 1..MAX_STREAMS
    logic          in_fire;
    logic [SW-1:0] ld_idx;
    logic [CW-1:0] adv_sum;
    logic [SW-1:0] adv_node;

    always_comb begin
        if (r_cfg == '0) begin
            n_live = CW'(1);
        end else if (int'(r_cfg) > MAX_STREAMS) begin
            n_live = CW'(MAX_STREAMS);
        end else begin
            n_live = CW'(r_cfg);
        end
    end

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == ltkm_pkg::ST_IDLE);
    assign in_fire     = i_in.valid && i_in.ready;
    assign ld_idx      = SW'(i_in.stream);

    // leaf of the current winner sits at node winner + n, its parent one level up
    assign adv_sum  = CW'(r_winner) + n_live;
    assign adv_node = adv_sum[SW:1];

    assign l_rd = r_lrd_v ? r_lrd : '0;

    assign o_out.valid         = r_out_valid;
    assign o_out.winner_stream = r_o_stream;
    assign o_out.winner_key    = r_o_key;
    assign o_out.winner_valid  = r_o_kv;

    // ------------------------------------------------------------------------
    // memories
    // ------------------------------------------------------------------------
    // head keys, written by load and advance
    ltkm_ram #(
        .WIDTH (KW),
        .DEPTH (MAX_STREAMS)
    ) u_keys (
        .i_clk     (i_clk),
        .i_we      (k_we),
        .i_waddr   (k_waddr),
        .i_wdata   (k_wdata),
        .i_re_a    (k_re_a),
        .i_raddr_a (k_raddr_a),
        .o_rdata_a (k_rdata_a),
        .i_re_b    (k_re_b),
        .i_raddr_b (k_raddr_b),
        .o_rdata_b (k_rdata_b)
    );

    // subtree winners, scratch for build only
    ltkm_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_STREAMS)
    ) u_wins (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_re_a    (w_re_a),
        .i_raddr_a (w_raddr_a),
        .o_rdata_a (w_rdata_a),
        .i_re_b    (w_re_b),
        .i_raddr_b (w_raddr_b),
        .o_rdata_b (w_rdata_b)
    );

    always_ff @(posedge i_clk) begin
        if (lw_en) begin
            r_lmem[lw_addr] <= lw_data;
        end
        if (lr_en) begin
            r_lrd <= r_lmem[r_node];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvalid <= '0;
            r_lrd_v  <= 1'b0;
        end else begin
            if (lw_en) begin
                r_lvalid[lw_addr] <= 1'b1;
            end
            if (lr_en) begin
                r_lrd_v <= r_lvalid[r_node];
            end
        end
    end

    // ------------------------------------------------------------------------
    // sequencer: next state, memory controls and datapath updates
    // ------------------------------------------------------------------------
    always_comb begin
        logic [CW-1:0]        c0, c1;
        logic [SW-1:0]        l_sel, r_sel, lose, win, f;
        logic                 pl, pr, swap;

        n_state     = r_state;
        n_present   = r_present;
        n_winner    = r_winner;
        n_i         = r_i;
        n_node      = r_node;
        n_cur_key   = r_cur_key;
        n_cur_pres  = r_cur_pres;
        n_l         = r_l;
        n_r         = r_r;
        n_l_leaf    = r_l_leaf;
        n_r_leaf    = r_r_leaf;
        n_out_valid = r_out_valid;
        n_o_stream  = r_o_stream;
        n_o_key     = r_o_key;
        n_o_kv      = r_o_kv;

        k_we = 1'b0; k_waddr = '0; k_wdata = '0;
        k_re_a = 1'b0; k_raddr_a = '0; k_re_b = 1'b0; k_raddr_b = '0;
        w_we = 1'b0; w_waddr = '0; w_wdata = '0;
        w_re_a = 1'b0; w_raddr_a = '0; w_re_b = 1'b0; w_raddr_b = '0;
        lw_en = 1'b0; lw_addr = '0; lw_data = '0; lr_en = 1'b0;

        c0    = {r_i, 1'b0};
        c1    = {r_i, 1'b1};
        l_sel = r_l_leaf ? r_l : w_rdata_a;
        r_sel = r_r_leaf ? r_r : w_rdata_b;
        pl    = r_present[r_l];
        pr    = r_present[r_r];
        f     = l_rd;

        // absent heads lose, equal keys give the right side
        if (!pl || !pr) begin
            lose = pl ? r_r : r_l;
        end else begin
            lose = ltkm_pkg::key_less(k_rdata_a, k_rdata_b) ? r_r : r_l;
        end
        win = (lose == r_l) ? r_r : r_l;

        // challenger takes over only when strictly better
        swap = r_present[r_l] && (!r_cur_pres || ltkm_pkg::key_less(k_rdata_a, r_cur_key));

        if (o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ltkm_pkg::ST_IDLE: begin
                if (in_fire) begin
                    case (i_in.action)
                        ltkm_pkg::ACT_LOAD: begin
                            if (int'(i_in.stream) < MAX_STREAMS) begin
                                k_we              = 1'b1;
                                k_waddr           = ld_idx;
                                k_wdata           = i_in.key;
                                n_present[ld_idx] = i_in.key_valid;
                            end
                        end
                        ltkm_pkg::ACT_BUILD: begin
                            if (n_live == CW'(1)) begin
                                n_winner = '0;
                                n_state  = ltkm_pkg::ST_E_READ;
                            end else begin
                                n_i     = SW'(n_live - CW'(1));
                                n_state = ltkm_pkg::ST_B_ADDR;
                            end
                        end
                        ltkm_pkg::ACT_ADVANCE: begin
                            // nothing left in the winning stream: tree unchanged
                            if (r_present[r_winner]) begin
                                k_we                = 1'b1;
                                k_waddr             = r_winner;
                                k_wdata             = i_in.key;
                                n_present[r_winner] = i_in.key_valid;
                                n_cur_key           = i_in.key;
                                n_cur_pres          = i_in.key_valid;
                                n_node              = adv_node;
                                n_state             = (adv_node == '0) ? ltkm_pkg::ST_E_READ
                                                                       : ltkm_pkg::ST_A_NODE;
                            end else begin
                                n_state = ltkm_pkg::ST_E_READ;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ltkm_pkg::ST_B_ADDR: begin
                // children at or above n are leaves, their stream is node - n
                w_re_a    = 1'b1;
                w_raddr_a = SW'(c0);
                w_re_b    = 1'b1;
                w_raddr_b = SW'(c1);
                n_l_leaf  = (c0 >= n_live);
                n_r_leaf  = (c1 >= n_live);
                n_l       = SW'(c0 - n_live);
                n_r       = SW'(c1 - n_live);
                n_state   = ltkm_pkg::ST_B_KEY;
            end
            ltkm_pkg::ST_B_KEY: begin
                k_re_a    = 1'b1;
                k_raddr_a = l_sel;
                k_re_b    = 1'b1;
                k_raddr_b = r_sel;
                n_l       = l_sel;
                n_r       = r_sel;
                n_state   = ltkm_pkg::ST_B_CMP;
            end
            ltkm_pkg::ST_B_CMP: begin
                lw_en   = 1'b1;
                lw_addr = r_i;
                lw_data = lose;
                w_we    = 1'b1;
                w_waddr = r_i;
                w_wdata = win;
                if (r_i == SW'(1)) begin
                    n_winner = win;
                    n_state  = ltkm_pkg::ST_E_READ;
                end else begin
                    n_i     = r_i - SW'(1);
                    n_state = ltkm_pkg::ST_B_ADDR;
                end
            end
            ltkm_pkg::ST_A_NODE: begin
                lr_en   = 1'b1;
                n_state = ltkm_pkg::ST_A_KEY;
            end
            ltkm_pkg::ST_A_KEY: begin
                k_re_a    = 1'b1;
                k_raddr_a = f;
                n_l       = f;
                n_state   = ltkm_pkg::ST_A_CMP;
            end
            ltkm_pkg::ST_A_CMP: begin
                lw_en   = 1'b1;
                lw_addr = r_node;
                lw_data = swap ? r_winner : r_l;
                if (swap) begin
                    n_winner   = r_l;
                    n_cur_key  = k_rdata_a;
                    n_cur_pres = 1'b1;
                end
                n_node  = r_node >> 1;
                n_state = ((r_node >> 1) == '0) ? ltkm_pkg::ST_E_READ : ltkm_pkg::ST_A_NODE;
            end
            ltkm_pkg::ST_E_READ: begin
                k_re_a    = 1'b1;
                k_raddr_a = r_winner;
                n_state   = ltkm_pkg::ST_E_OUT;
            end
            ltkm_pkg::ST_E_OUT: begin
                // wait here while the previous result is still held
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_o_stream  = ltkm_pkg::SID_W'(r_winner);
                    n_o_kv      = r_present[r_winner];
                    n_o_key     = r_present[r_winner] ? k_rdata_a : '0;
                    n_state     = ltkm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ltkm_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // state registers
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ltkm_pkg::ST_IDLE;
            r_cfg       <= ltkm_pkg::CFG_RESET;
            r_present   <= '0;
            r_winner    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_present   <= n_present;
            r_winner    <= n_winner;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                r_cfg <= i_cfg.streams_in_use;
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge i_clk) begin
        r_i        <= n_i;
        r_node     <= n_node;
        r_cur_key  <= n_cur_key;
        r_cur_pres <= n_cur_pres;
        r_l        <= n_l;
        r_r        <= n_r;
        r_l_leaf   <= n_l_leaf;
        r_r_leaf   <= n_r_leaf;
        r_o_stream <= n_o_stream;
        r_o_key    <= n_o_key;
        r_o_kv     <= n_o_kv;
    end

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    // loser memory is only written at a compare step
    a_lw_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lw_en |-> (r_state == ltkm_pkg::ST_B_CMP || r_state == ltkm_pkg::ST_A_CMP))
        else $error("loser write outside a compare step");

    // the path walk never visits the root sentinel
    a_node_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ltkm_pkg::ST_A_NODE) |-> (r_node != '0))
        else $error("advance walk reached node zero");

    // a held result is never overwritten
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ltkm_pkg::ST_E_OUT && r_out_valid && !o_out.ready)
            |=> (r_state == ltkm_pkg::ST_E_OUT && r_out_valid))
        else $error("result register overrun");

    // build and advance always leave idle to produce a result
    a_result_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && (i_in.action == ltkm_pkg::ACT_BUILD || i_in.action == ltkm_pkg::ACT_ADVANCE))
            |=> (r_state != ltkm_pkg::ST_IDLE))
        else $error("build or advance produced no work");

    // the winner always names a stream that exists
    a_winner_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_winner) < MAX_STREAMS)
        else $error("winner index out of range");

endmodule

FILE: test/loser_tree_kway_merge_top_test.sv
// ----------------------------------------------------------------------------
// loser_tree_kway_merge_top_test
// self-checking bench for the loser tree merge: a short table of directed
// transactions, then randomized merge runs over several stream counts, every
// winner checked against a behavioral copy of the tree kept in this bench
// ----------------------------------------------------------------------------
module loser_tree_kway_merge_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS       = 8;
    localparam int PHASE_ITEMS = 85;
    localparam int SETTLE      = 40;    // longer than a full build over eight streams
    localparam int HOLD_CYCLES = 400;

    // action code the block must drop without a result
    localparam logic [ltkm_pkg::ACT_W-1:0] ACT_UNUSED = 2'd3;

    localparam logic signed [ltkm_pkg::KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [ltkm_pkg::KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

    // receiver stall patterns
    localparam int RX_OPEN   = 0;
    localparam int RX_HALF   = 1;
    localparam int RX_SPARSE = 2;
    localparam int RX_TOGGLE = 3;

    typedef struct packed {
        logic [ltkm_pkg::ACT_W-1:0]        act;
        logic [ltkm_pkg::SID_W-1:0]        sid;
        logic signed [ltkm_pkg::KEY_W-1:0] key;
        logic                              kv;
    } t_item;

    typedef struct packed {
        logic [ltkm_pkg::SID_W-1:0]        sid;
        logic signed [ltkm_pkg::KEY_W-1:0] key;
        logic                              valid;
    } t_win;

    // one directed row: the transaction, and a typed winner where it is obvious
    typedef struct packed {
        t_item it;
        logic  known;
        t_win  want;
    } t_row;

    // directed part, run with the reset stream count of eight
    localparam t_row PLAN [24] = '{
        // advance before anything is loaded: no head, no walk
        '{'{ltkm_pkg::ACT_ADVANCE, 3'd0, 32'sd5,  1'b1}, 1'b1, '{3'd0, 32'sd0, 1'b0}},
        // build over eight empty streams: the right side wins every match, so the rightmost leaf wins
        '{'{ltkm_pkg::ACT_BUILD,   3'd0, 32'sd0,  1'b0}, 1'b1, '{3'd7, 32'sd0, 1'b0}},
        '{'{ltkm_pkg::ACT_LOAD,    3'd0, KEY_MIN, 1'b1}, 1'b0, '0},
        '{'{ltkm_pkg::ACT_LOAD,    3'd1, KEY_MAX, 1'b1}, 1'b0, '0},
        '{'{ltkm_pkg::ACT_LOAD,    3'd2, 32'sd0,  1'b1}, 1'b0, '0},
        '{'{ltkm_pkg::ACT_LOAD,    3'd3, -32'sd1, 1'b1}, 1'b0, '0},
        '{'{ltkm_pkg::ACT_LOAD,    3'd4, 32'sd0,  1'b1}, 1'b0, '0},
        // empty stream that still carries key bits
        '{'{ltkm_pkg::ACT_LOAD,    3'd5, 32'sh5555_5555, 1'b0}, 1'b0, '0},
        '{'{ltkm_pkg::ACT_LOAD,    3'd6, 32'shAAAA_AAAA, 1'b1}, 1'b0, '0},
        '{'{ltkm_pkg::ACT_LOAD,    3'd7, KEY_MAX, 1'b1}, 1'b0, '0},
        // most negative key is the unique minimum
        '{'{ltkm_pkg::ACT_BUILD,   3'd5, 32'sd9,  1'b1}, 1'b1, '{3'd0, KEY_MIN, 1'b1}},
        // equal key on advance: the climbing stream stays the winner
        '{'{ltkm_pkg::ACT_ADVANCE, 3'd2, KEY_MIN, 1'b1}, 1'b1, '{3'd0, KEY_MIN, 1'b1}},
        '{'{ltkm_pkg::ACT_ADVANCE, 3'd0, KEY_MAX, 1'b1}, 1'b0, '0},
        '{'{ltkm_pkg::ACT_ADVANCE, 3'd0, 32'sd0,  1'b0}, 1'b0, '0},
        '{'{ACT_UNUSED,            3'd3, KEY_MAX, 1'b1}, 1'b0, '0},
        '{'{ltkm_pkg::ACT_ADVANCE, 3'd7, -32'sd1, 1'b1}, 1'b0, '0},
        '{'{ltkm_pkg::ACT_ADVANCE, 3'd1, 32'sd0,  1'b1}, 1'b0, '0},
        // drain the six heads left
        '{'{ltkm_pkg::ACT_ADVANCE, 3'd0, KEY_MIN, 1'b0}, 1'b0, '0},
        '{'{ltkm_pkg::ACT_ADVANCE, 3'd0, KEY_MAX, 1'b0}, 1'b0, '0},
        '{'{ltkm_pkg::ACT_ADVANCE, 3'd0, 32'sd1,  1'b0}, 1'b0, '0},
        '{'{ltkm_pkg::ACT_ADVANCE, 3'd0, -32'sd2, 1'b0}, 1'b0, '0},
        '{'{ltkm_pkg::ACT_ADVANCE, 3'd0, 32'sd3,  1'b0}, 1'b0, '0},
        '{'{ltkm_pkg::ACT_ADVANCE, 3'd0, 32'sd4,  1'b0}, 1'b0, '0},
        // nothing left: the next key is dropped
        '{'{ltkm_pkg::ACT_ADVANCE, 3'd0, 32'sh1234_5678, 1'b1}, 1'b0, '0}
    };

    // stream counts for the random phases, out-of-range values included
    localparam logic [ltkm_pkg::CFG_W-1:0] CFG_PLAN [12] = '{
        4'd1, 4'd0, 4'd15, 4'd3, 4'd8, 4'd2, 4'd5, 4'd9, 4'd7, 4'd4, 4'd6, 4'd8
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    ltkm_in_if  in_ch ();
    ltkm_out_if out_ch ();
    ltkm_cfg_if cfg_ch ();

    loser_tree_kway_merge_top #(
        .MAX_STREAMS(SLOTS)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always #10 i_clk = ~i_clk;

    // behavioral copy of the tree
    logic signed [ltkm_pkg::KEY_W-1:0] head_key  [SLOTS];
    logic                              head_live [SLOTS];
    logic [ltkm_pkg::SID_W-1:0]        loser_of  [SLOTS];
    logic [ltkm_pkg::SID_W-1:0]        champ;
    logic [ltkm_pkg::CFG_W-1:0]        streams_cfg;

    // winners still owed by the block, oldest first
    t_win pending_winners [$];

    int errors       = 0;
    int accepted     = 0;
    int counted      = 0;
    int burst_left   = 0;
    int n_load       = 0;
    int n_build      = 0;
    int n_advance    = 0;
    int n_ignored    = 0;
    int n_checked    = 0;
    int n_drained    = 0;
    int rx_mode      = RX_OPEN;
    int rx_mode_left = 0;
    logic rx_hold;

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // stream count actually used: zero acts as one, above the slot count clamps
    function automatic int tree_width();
        if (streams_cfg == '0) return 1;
        if (int'(streams_cfg) > SLOTS) return SLOTS;
        return int'(streams_cfg);
    endfunction

    function automatic void rebuild_tree();
        logic [ltkm_pkg::SID_W-1:0] win [2*SLOTS];
        logic [ltkm_pkg::SID_W-1:0] l;
        logic [ltkm_pkg::SID_W-1:0] r;
        logic [ltkm_pkg::SID_W-1:0] lose;
        int n;
        n = tree_width();
        for (int i = 0; i < n; i++) win[n+i] = ltkm_pkg::SID_W'(i);
        for (int i = n - 1; i >= 1; i--) begin
            l = win[2*i];
            r = win[2*i+1];
            // absent heads lose; on a tie the right side wins
            if (!head_live[l] || !head_live[r]) begin
                lose = head_live[l] ? r : l;
            end else begin
                lose = (head_key[l] < head_key[r]) ? r : l;
            end
            loser_of[i] = lose;
            win[i] = (lose == l) ? r : l;
        end
        champ = win[1];
    endfunction

    function automatic void replay_path(input logic signed [ltkm_pkg::KEY_W-1:0] key,
                                        input logic kv);
        logic [ltkm_pkg::SID_W-1:0] cur;
        logic [ltkm_pkg::SID_W-1:0] f;
        logic [ltkm_pkg::SID_W-1:0] t;
        int node;
        cur = champ;
        if (!head_live[cur]) return;
        head_key[cur]  = key;
        head_live[cur] = kv;
        node = (int'(cur) + tree_width()) >> 1;
        while (node != 0) begin
            f = loser_of[node % SLOTS];
            // the stored loser takes over only when strictly smaller
            if (head_live[f] && (!head_live[cur] || head_key[f] < head_key[cur])) begin
                t   = cur;
                cur = f;
                f   = t;
            end
            loser_of[node % SLOTS] = f;
            node = node >> 1;
        end
        champ = cur;
    endfunction

    // applies one transaction, returns 1 with the winner it reports
    function automatic bit predict_winner(input t_item it, output t_win res);
        res = '0;
        case (it.act)
            ltkm_pkg::ACT_LOAD: begin
                head_key[it.sid]  = it.key;
                head_live[it.sid] = it.kv;
                return 1'b0;
            end
            ltkm_pkg::ACT_BUILD:   rebuild_tree();
            ltkm_pkg::ACT_ADVANCE: replay_path(it.key, it.kv);
            default:               return 1'b0;
        endcase
        res.sid   = champ;
        res.valid = head_live[champ];
        res.key   = head_live[champ] ? head_key[champ] : '0;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // narrow keys crowd into a few values so ties show up often
    function automatic logic signed [ltkm_pkg::KEY_W-1:0] pick_key(input bit narrow);
        int d;
        d = $urandom_range(0, 8);
        case ($urandom_range(0, 15))
            0:       return KEY_MIN;
            1:       return KEY_MAX;
            default: return narrow ? ltkm_pkg::KEY_W'(d - 4) : ltkm_pkg::KEY_W'($urandom);
        endcase
    endfunction

    function automatic t_item noise_item();
        t_item it;
        it.act = ltkm_pkg::ACT_W'($urandom_range(0, 3));
        it.sid = ltkm_pkg::SID_W'($urandom_range(0, SLOTS - 1));
        it.key = pick_key(1'($urandom_range(0, 1)));
        it.kv  = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // offers one transaction in bursts with random gaps, waits for it to be
    // taken, then records the winner it will produce
    task automatic offer(input t_item it, input logic typed, input t_win want);
        int gap;
        t_win guess;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_ch.valid     <= 1'b1;
        in_ch.action    <= it.act;
        in_ch.stream    <= it.sid;
        in_ch.key       <= it.key;
        in_ch.key_valid <= it.kv;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        accepted++;
        if (predict_winner(it, guess)) pending_winners.push_back(typed ? want : guess);
        case (it.act)
            ltkm_pkg::ACT_LOAD:    n_load++;
            ltkm_pkg::ACT_BUILD:   n_build++;
            ltkm_pkg::ACT_ADVANCE: n_advance++;
            default:               n_ignored++;
        endcase
        if (it.act != ACT_UNUSED) counted++;
    endtask

    // stop offering, let every owed winner arrive, then let the block go idle
    task automatic drain();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (pending_winners.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_streams(input logic [ltkm_pkg::CFG_W-1:0] value);
        cfg_ch.valid          <= 1'b1;
        cfg_ch.streams_in_use <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        streams_cfg = value;
    endtask

    // a well-formed merge: sorted lanes per stream, heads loaded, one build,
    // then advance the current winner with its lane's next key until all
    // lanes are spent; a few builds are skipped so a stale tree gets walked
    task automatic run_merge();
        int lane [SLOTS][$];
        int n;
        int steps;
        bit narrow;
        bit skip_build;
        logic [ltkm_pkg::SID_W-1:0] w;
        t_item it;
        n          = tree_width();
        narrow     = 1'($urandom_range(0, 1));
        skip_build = ($urandom_range(0, 9) == 0);
        for (int s = 0; s < SLOTS; s++) begin
            lane[s] = {};
            if (s < n) repeat ($urandom_range(0, 5)) lane[s].push_back(int'(pick_key(narrow)));
            lane[s].sort();
        end
        for (int s = 0; s < n; s++) begin
            it.act = ltkm_pkg::ACT_LOAD;
            it.sid = ltkm_pkg::SID_W'(s);
            if (lane[s].size() != 0) begin
                it.key = lane[s].pop_front();
                it.kv  = 1'b1;
            end else begin
                it.key = $urandom;
                it.kv  = 1'b0;
            end
            offer(it, 1'b0, '0);
        end
        if (!skip_build) begin
            it.act = ltkm_pkg::ACT_BUILD;
            it.sid = ltkm_pkg::SID_W'($urandom_range(0, SLOTS - 1));
            it.key = $urandom;
            it.kv  = 1'($urandom_range(0, 1));
            offer(it, 1'b0, '0);
        end
        steps = 0;
        while (steps < 48) begin
            // an occasional stray transaction breaks the sequence
            if ($urandom_range(0, 15) == 0) offer(noise_item(), 1'b0, '0);
            w      = champ;
            it.act = ltkm_pkg::ACT_ADVANCE;
            it.sid = ltkm_pkg::SID_W'($urandom_range(0, SLOTS - 1));
            if (!head_live[w]) begin
                // everything spent: one more advance whose key is dropped
                it.key = $urandom;
                it.kv  = 1'($urandom_range(0, 1));
                offer(it, 1'b0, '0);
                break;
            end
            if (lane[w].size() != 0) begin
                it.key = lane[w].pop_front();
                it.kv  = 1'b1;
            end else begin
                it.key = $urandom;
                it.kv  = 1'b0;
            end
            offer(it, 1'b0, '0);
            steps++;
        end
    endtask

    // ------------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------------

    task automatic check_winner();
        t_win want;
        if (pending_winners.size() == 0) begin
            $error("winner with none owed: stream %0d key %0d valid %0b",
                   out_ch.winner_stream, out_ch.winner_key, out_ch.winner_valid);
            errors++;
            return;
        end
        want = pending_winners.pop_front();
        n_checked++;
        if (!want.valid) n_drained++;
        if (out_ch.winner_stream !== want.sid) begin
            $error("winner_stream: expected %0d, actual %0d", want.sid, out_ch.winner_stream);
            errors++;
        end
        if (out_ch.winner_key !== want.key) begin
            $error("winner_key: expected %0d, actual %0d", want.key, out_ch.winner_key);
            errors++;
        end
        if (out_ch.winner_valid !== want.valid) begin
            $error("winner_valid: expected %0b, actual %0b", want.valid, out_ch.winner_valid);
            errors++;
        end
    endtask

    // receiver: checks each transaction and stalls on a pattern that switches
    // between open, half, sparse and toggling stretches
    initial begin : result_sink
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) check_winner();
            if (rx_mode_left == 0) begin
                rx_mode_left = $urandom_range(16, 64);
                rx_mode      = $urandom_range(RX_OPEN, RX_TOGGLE);
            end
            rx_mode_left--;
            if (rx_hold) begin
                out_ch.ready <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_OPEN:   out_ch.ready <= 1'b1;
                    RX_HALF:   out_ch.ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: out_ch.ready <= ($urandom_range(0, 3) == 0);
                    default:   out_ch.ready <= ~out_ch.ready;
                endcase
            end
        end
    end

    // back-pressure: twice the receiver shuts for a long stretch while
    // the sender keeps offering, so the output register fills and the input stalls
    initial begin : long_hold
        rx_hold <= 1'b0;
        wait (accepted >= 300);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
        wait (accepted >= 800);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------

    initial begin : stimulus
        int phase_start;
        i_rst_n               <= 1'b0;
        in_ch.valid           <= 1'b0;
        in_ch.action          <= ltkm_pkg::ACT_LOAD;
        in_ch.stream          <= '0;
        in_ch.key             <= '0;
        in_ch.key_valid       <= 1'b0;
        cfg_ch.valid          <= 1'b0;
        cfg_ch.streams_in_use <= ltkm_pkg::CFG_RESET;

        // predictor starts from the reset state
        for (int s = 0; s < SLOTS; s++) begin
            head_key[s]  = '0;
            head_live[s] = 1'b0;
            loser_of[s]  = '0;
        end
        champ       = '0;
        streams_cfg = ltkm_pkg::CFG_RESET;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (PLAN[r]) offer(PLAN[r].it, PLAN[r].known, PLAN[r].want);

        // random phases, one stream count each, mostly well-formed merges
        foreach (CFG_PLAN[p]) begin
            drain();
            write_streams(CFG_PLAN[p]);
            phase_start = counted;
            while (counted - phase_start < PHASE_ITEMS) begin
                if ($urandom_range(0, 3) != 0) begin
                    run_merge();
                end else begin
                    repeat ($urandom_range(1, 8)) offer(noise_item(), 1'b0, '0);
                end
            end
        end

        drain();

        $display("run covered %0d transactions: %0d loads, %0d builds, %0d advances, %0d dropped",
                 accepted, n_load, n_build, n_advance, n_ignored);
        $display("%0d winners checked over %0d stream counts, %0d with every stream spent",
                 n_checked, $size(CFG_PLAN) + 1, n_drained);
        if (errors == 0) begin
            $display("loser_tree_kway_merge_top_test: done, clean");
        end else begin
            $display("loser_tree_kway_merge_top_test: done, errors");
        end
        $finish;
    end

    // hard limit on the whole run
    initial begin : watchdog
        #20_000_000;
        $display("loser_tree_kway_merge_top_test: done, errors");
        $finish;
    end

endmodule
